// ----- rtl/core/seb_pkg.sv -----
// ----------------------------------------------------------------------------
// seb_pkg
// shared constants, types and helpers of the sobel edge blend block
// ----------------------------------------------------------------------------
package seb_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_EDGE_WEIGHT  = 2'd2;
	localparam logic [1:0] REG_ORIG_WEIGHT  = 2'd3;

	localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
	localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd480;
	localparam logic [7:0]  EDGE_WEIGHT_RST  = 8'd205;
	localparam logic [7:0]  ORIG_WEIGHT_RST  = 8'd179;

	localparam logic [9:0] GRAY_RECIP = 10'd683;

	typedef struct packed {
		logic emit;
		logic interior;
		logic frame_end;
	} seb_ctrl_t;

	localparam int CTRL_W = $bits(seb_ctrl_t);

	// floor(sum/3) for sums up to 765 via reciprocal 683/2048
	function automatic logic [7:0] gray_of(input logic [31:0] px);
		logic [9:0]  sum;
		logic [19:0] prod;
		begin
			sum  = 10'(px[7:0]) + 10'(px[15:8]) + 10'(px[23:16]);
			prod = 20'(sum) * 20'(GRAY_RECIP);
			gray_of = prod[18:11];
		end
	endfunction

endpackage

// ----- rtl/core/seb_ram.sv -----
// ----------------------------------------------------------------------------
// seb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module seb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/seb_fifo.sv -----
// ----------------------------------------------------------------------------
// seb_fifo
// short register queue between the front and back parts
// ----------------------------------------------------------------------------
module seb_fifo import seb_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CNW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNW-1:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNW'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// ----- rtl/core/seb_front.sv -----
// ----------------------------------------------------------------------------
// seb_front
// accepts transactions, tracks the raster position and classifies each pixel
// ----------------------------------------------------------------------------
module seb_front import seb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int CIW = $clog2(MAX_WIDTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            opcode,
	input  logic [7:0]      red_in,
	input  logic [7:0]      green_in,
	input  logic [7:0]      blue_in,
	input  logic [7:0]      alpha_in,
	input  logic [12:0]     image_width,
	input  logic [15:0]     image_height,
	input  logic            q_full,
	output logic            push,
	output logic [31:0]     push_data,
	output logic [CIW-1:0]  push_idx,
	output seb_ctrl_t       push_ctrl
);

	localparam int CW = $clog2(MAX_WIDTH + 1);

	logic [CIW-1:0] col_q;
	logic [15:0]    row_q;
	logic [CW-1:0]  w_eff;
	logic [15:0]    h_eff;
	logic [CW-1:0]  c_ext;
	logic [CW:0]    qc;
	logic [17:0]    qr;
	logic           complete;
	logic           accept;
	logic           wrap;
	logic           emit;
	logic           interior;
	logic           fe;

	always_comb begin
		if (image_width < 13'd3) begin
			w_eff = CW'(3);
		end else if (int'(image_width) > MAX_WIDTH) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(image_width);
		end
		h_eff = (image_height < 16'd3) ? 16'd3 : image_height;
		c_ext = CW'(col_q);
		complete = (row_q >= h_eff);
		wrap = ((c_ext + CW'(1)) >= w_eff);
		emit = (row_q >= 16'd2) || (row_q == 16'd1 && col_q != '0);
		if (col_q != '0) begin
			qc = (CW+1)'(c_ext) - (CW+1)'(1);
			qr = 18'(row_q) - 18'd1;
		end else begin
			qc = (CW+1)'(w_eff) - (CW+1)'(1);
			qr = (row_q >= 16'd2) ? 18'(row_q) - 18'd2 : 18'd0;
		end
		interior = (qr >= 18'd1) && (qr + 18'd2 <= 18'(h_eff)) &&
			(qc >= (CW+1)'(1)) && (qc + (CW+1)'(2) <= (CW+1)'(w_eff));
		fe = (qr + 18'd1 >= 18'(h_eff)) && (qc + (CW+1)'(1) >= (CW+1)'(w_eff));
	end

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign push      = accept && (complete || !opcode);
	assign push_data = complete ? 32'd0 : {alpha_in, blue_in, green_in, red_in};
	assign push_idx  = col_q;
	assign push_ctrl = '{emit: emit, interior: interior, frame_end: fe};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (emit && fe) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= (row_q == 16'hFFFF) ? row_q : row_q + 16'd1;
			end else begin
				col_q <= col_q + CIW'(1);
			end
		end
	end

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(col_q) < MAX_WIDTH) else $error("column beyond row store");
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(push && emit && fe) |=> (col_q == '0 && row_q == '0))
		else $error("position not cleared after frame end");
	a_flush_held: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !complete && opcode) |-> !push) else $error("flush pushed in frame");

endmodule

// ----- rtl/core/seb_back.sv -----
// ----------------------------------------------------------------------------
// seb_back
// row stores, gray window, sobel, iterative square root and blend
// ----------------------------------------------------------------------------
module seb_back import seb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int CIW = $clog2(MAX_WIDTH)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  logic [31:0]    q_data,
	input  logic [CIW-1:0] q_idx,
	input  seb_ctrl_t      q_ctrl,
	output logic           pop,
	input  logic [7:0]     edge_weight,
	input  logic [7:0]     orig_weight,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     red_out,
	output logic [7:0]     green_out,
	output logic [7:0]     blue_out,
	output logic [7:0]     alpha_out,
	output logic           frame_end
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_SOBEL = 3'd2;
	localparam logic [2:0] ST_SQ    = 3'd3;
	localparam logic [2:0] ST_ROOT  = 3'd4;
	localparam logic [2:0] ST_BLEND = 3'd5;

	logic [2:0]           state_q;
	logic [31:0]          data_q;
	logic [CIW-1:0]       idx_q;
	seb_ctrl_t            ctrl_q;
	logic [31:0]          up_rd;
	logic [31:0]          mid_rd;
	logic                 ram_we;
	logic [7:0]           gw_q [3][3];
	logic [31:0]          center_q;
	logic [31:0]          orig_q;
	logic signed [11:0]   sx_q;
	logic signed [11:0]   sy_q;
	logic signed [11:0]   sx;
	logic signed [11:0]   sy;
	logic [21:0]          rem_q;
	logic [21:0]          res_q;
	logic [21:0]          bit_q;
	logic [22:0]          trial;
	logic [7:0]           edge_v;
	logic [7:0]           edge_a;
	logic                 load_out;
	logic                 out_valid_q;

	function automatic logic [7:0] blend(input logic [7:0] e, input logic [7:0] ch,
		input logic [7:0] ew, input logic [7:0] ow);
		logic [16:0] acc;
		begin
			acc = 17'(16'(e) * 16'(ew)) + 17'(16'(ch) * 16'(ow));
			blend = (acc[16:8] > 9'd255) ? 8'd255 : acc[15:8];
		end
	endfunction

	assign pop    = (state_q == ST_IDLE) && !q_empty;
	assign ram_we = (state_q == ST_READ);

	seb_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_upper (
		.clk(clk), .we(ram_we), .waddr(idx_q), .wdata(mid_rd),
		.raddr(q_idx), .rdata(up_rd)
	);

	seb_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_lower (
		.clk(clk), .we(ram_we), .waddr(idx_q), .wdata(data_q),
		.raddr(q_idx), .rdata(mid_rd)
	);

	always_comb begin
		sx = (12'(gw_q[0][2]) + 12'(2 * 12'(gw_q[1][2])) + 12'(gw_q[2][2])) -
			(12'(gw_q[0][0]) + 12'(2 * 12'(gw_q[1][0])) + 12'(gw_q[2][0]));
		sy = (12'(gw_q[0][0]) + 12'(2 * 12'(gw_q[0][1])) + 12'(gw_q[0][2])) -
			(12'(gw_q[2][0]) + 12'(2 * 12'(gw_q[2][1])) + 12'(gw_q[2][2]));
		trial  = 23'(res_q) + 23'(bit_q);
		edge_v = (res_q > 22'd255) ? 8'd255 : res_q[7:0];
		edge_a = ctrl_q.interior ? orig_q[31:24] : 8'd0;
	end

	assign load_out  = (state_q == ST_BLEND) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			center_q    <= '0;
			orig_q      <= '0;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					gw_q[k][j] <= '0;
				end
			end
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					for (int k = 0; k < 3; k++) begin
						gw_q[k][0] <= gw_q[k][1];
						gw_q[k][1] <= gw_q[k][2];
					end
					gw_q[0][2] <= gray_of(up_rd);
					gw_q[1][2] <= gray_of(mid_rd);
					gw_q[2][2] <= gray_of(data_q);
					orig_q   <= center_q;
					center_q <= mid_rd;
					state_q  <= ctrl_q.emit ? ST_SOBEL : ST_IDLE;
				end
				ST_SOBEL: begin
					state_q <= ctrl_q.interior ? ST_SQ : ST_BLEND;
				end
				ST_SQ: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (bit_q[1:0] != 2'b00) begin
						state_q <= ST_BLEND;
					end
				end
				ST_BLEND: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= q_data;
			idx_q  <= q_idx;
			ctrl_q <= q_ctrl;
		end
		if (state_q == ST_SOBEL) begin
			sx_q  <= sx;
			sy_q  <= sy;
			res_q <= '0;
		end
		if (state_q == ST_SQ) begin
			rem_q <= 22'(24'(sx_q * sx_q) + 24'(sy_q * sy_q));
			res_q <= '0;
			bit_q <= 22'h100000;
		end
		if (state_q == ST_ROOT) begin
			if (23'(rem_q) >= trial) begin
				rem_q <= rem_q - trial[21:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (load_out) begin
			red_out   <= blend(edge_v, orig_q[7:0], edge_weight, orig_weight);
			green_out <= blend(edge_v, orig_q[15:8], edge_weight, orig_weight);
			blue_out  <= blend(edge_v, orig_q[23:16], edge_weight, orig_weight);
			alpha_out <= blend(edge_a, orig_q[31:24], edge_weight, orig_weight);
			frame_end <= ctrl_q.frame_end;
		end
	end

	a_root_interior: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT) |-> (ctrl_q.emit && ctrl_q.interior))
		else $error("square root on a non interior pixel");
	a_blend_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLEND) |-> ctrl_q.emit) else $error("blend without result");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid) else $error("loaded result not shown");

endmodule

// ----- rtl/core/sobel_edge_blend_top.sv -----
// ----------------------------------------------------------------------------
// sobel_edge_blend_top
// streaming 3x3 sobel edge detector blended onto the source pixels
// ----------------------------------------------------------------------------
// latency: a result comes out width+1 transactions after its pixel
// pacing: a pixel is taken from the queue only once the last one is through; interior
//   results wait on the 11 step square root unit, and an output stall holds the blend
// reset: asynchronous, clears position, queue, window and registers to defaults;
//   row stores are not cleared and need no clearing pass
module sobel_edge_blend_top import seb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic [7:0]  alpha_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [7:0]  alpha_out,
	output logic        frame_end
);

	localparam int CIW = $clog2(MAX_WIDTH);
	localparam int QW  = 32 + CIW + CTRL_W;

	logic [12:0]    image_width_q;
	logic [15:0]    image_height_q;
	logic [7:0]     edge_weight_q;
	logic [7:0]     orig_weight_q;
	logic           q_full;
	logic           q_empty;
	logic           push;
	logic           pop;
	logic [31:0]    push_data;
	logic [CIW-1:0] push_idx;
	seb_ctrl_t      push_ctrl;
	logic [QW-1:0]  q_rdata;
	seb_ctrl_t      q_ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
			edge_weight_q  <= EDGE_WEIGHT_RST;
			orig_weight_q  <= ORIG_WEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[12:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				REG_EDGE_WEIGHT:  edge_weight_q  <= cfg_data[7:0];
				REG_ORIG_WEIGHT:  orig_weight_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	seb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
		.image_width(image_width_q), .image_height(image_height_q),
		.q_full(q_full), .push(push), .push_data(push_data),
		.push_idx(push_idx), .push_ctrl(push_ctrl)
	);

	seb_fifo #(.WIDTH(QW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata({push_data, push_idx, push_ctrl}), .full(q_full),
		.pop(pop), .rdata(q_rdata), .empty(q_empty)
	);

	assign q_ctrl = q_rdata[CTRL_W-1:0];

	seb_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_data(q_rdata[QW-1:QW-32]),
		.q_idx(q_rdata[CTRL_W+CIW-1:CTRL_W]), .q_ctrl(q_ctrl), .pop(pop),
		.edge_weight(edge_weight_q), .orig_weight(orig_weight_q),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.alpha_out(alpha_out), .frame_end(frame_end)
	);

endmodule

// ----- verif/tb_sobel_edge_blend_top.sv -----
// ----------------------------------------------------------------------------
// tb_sobel_edge_blend_top
// Self-checking bench for the sobel edge blend block. Frames of random pixels
// are streamed in raster order under several size and weight settings. A
// behavioral model of the line stores, gray window, sobel magnitude and blend
// predicts every output pixel, and the output stream is compared in order.
// ----------------------------------------------------------------------------
module tb_sobel_edge_blend_top;
	import seb_pkg::*;

	localparam int MAXW      = 4096;
	localparam int STALL_MAX = 2000;
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] r, g, b, a;
	} pix_t;

	typedef struct packed {
		logic [7:0] r, g, b, a;
		logic       fe;
	} res_t;

	logic        clk, arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid, in_stall, opcode;
	logic [7:0]  red_in, green_in, blue_in, alpha_in;
	logic        out_valid, out_stall;
	logic [7:0]  red_out, green_out, blue_out, alpha_out;
	logic        frame_end;

	sobel_edge_blend_top i_dut (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// model state
	logic [31:0] m_upper [MAXW];
	logic [31:0] m_lower [MAXW];
	logic [7:0]  m_win [3][3];
	logic [31:0] m_center;
	int unsigned m_col, m_row;
	int unsigned m_w, m_h, m_ew, m_ow;

	pix_t pending_pixels [$];
	res_t expected_pixels [$];
	int   errors, results_seen, quiet_cycles;
	bit   no_idle, drain_done;

	function automatic logic [7:0] gray8(logic [31:0] px);
		return 8'((int'(px[7:0]) + int'(px[15:8]) + int'(px[23:16])) / 3);
	endfunction

	function automatic int unsigned root_floor(int unsigned v);
		int unsigned x;
		x = 0;
		while ((x + 1) * (x + 1) <= v) x++;
		return x;
	endfunction

	function automatic logic [7:0] mix(int unsigned e, int unsigned c);
		int unsigned v;
		v = (e * m_ew + c * m_ow) >> 8;
		return v > 255 ? 8'd255 : 8'(v);
	endfunction

	task automatic predict_pixel(pix_t p);
		int unsigned w, h, r, c, idx, qr, qc, e, ea;
		logic [31:0] data, up, mid, orig;
		int sx, sy;
		bit emit;
		res_t res;
		w = m_w < 3 ? 3 : (m_w > MAXW ? MAXW : m_w);
		h = m_h < 3 ? 3 : m_h;
		r = m_row;
		c = m_col;
		if (r < h && p.op == OP_FLUSH) return;
		data = (r >= h) ? 32'd0 : {p.a, p.b, p.g, p.r};
		idx = c < MAXW ? c : MAXW - 1;
		up = m_upper[idx];
		mid = m_lower[idx];
		m_upper[idx] = mid;
		m_lower[idx] = data;
		for (int k = 0; k < 3; k++) begin
			m_win[k][0] = m_win[k][1];
			m_win[k][1] = m_win[k][2];
		end
		m_win[0][2] = gray8(up);
		m_win[1][2] = gray8(mid);
		m_win[2][2] = gray8(data);
		orig = m_center;
		m_center = mid;
		emit = (r >= 2) || (r == 1 && c >= 1);
		if (c >= 1) begin
			qc = c - 1; qr = r - 1;
		end else begin
			qc = w - 1; qr = r >= 2 ? r - 2 : 0;
		end
		if (c + 1 >= w) begin
			m_col = 0;
			m_row = r >= 65535 ? 65535 : r + 1;
		end else begin
			m_col = c + 1;
		end
		if (!emit) return;
		e = 0;
		ea = 0;
		if (qr >= 1 && qr + 2 <= h && qc >= 1 && qc + 2 <= w) begin
			sx = (m_win[0][2] + 2 * m_win[1][2] + m_win[2][2])
				- (m_win[0][0] + 2 * m_win[1][0] + m_win[2][0]);
			sy = (m_win[0][0] + 2 * m_win[0][1] + m_win[0][2])
				- (m_win[2][0] + 2 * m_win[2][1] + m_win[2][2]);
			e = root_floor(sx * sx + sy * sy);
			if (e > 255) e = 255;
			ea = orig[31:24];
		end
		res.fe = (qr + 1 >= h && qc + 1 >= w);
		res.r = mix(e, orig[7:0]);
		res.g = mix(e, orig[15:8]);
		res.b = mix(e, orig[23:16]);
		res.a = mix(ea, orig[31:24]);
		expected_pixels.push_back(res);
		if (res.fe) begin
			m_col = 0;
			m_row = 0;
		end
	endtask

	function automatic pix_t rand_pixel();
		pix_t p;
		p.op = OP_PIXEL;
		p.r = 8'($urandom);
		p.g = 8'($urandom);
		p.b = 8'($urandom);
		p.a = 8'($urandom);
		return p;
	endfunction

	task automatic wait_idle();
		while (pending_pixels.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
		repeat (MAXW + 40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(v);
		@(posedge clk);
		case (idx)
			REG_IMAGE_WIDTH:  m_w = v & 16'h1fff;
			REG_IMAGE_HEIGHT: m_h = v & 16'hffff;
			REG_EDGE_WEIGHT:  m_ew = v & 8'hff;
			default:          m_ow = v & 8'hff;
		endcase
	endtask

	task automatic setup(int unsigned w, int unsigned h, int unsigned ew, int unsigned ow);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_EDGE_WEIGHT, ew);
		write_reg(REG_ORIG_WEIGHT, ow);
		cfg_we <= 1'b0;
	endtask

	// one frame plus flushes to drain; noise inserts stray flush ticks
	task automatic queue_frame(int unsigned w, int unsigned h, bit noise);
		pix_t p;
		for (int i = 0; i < w * h; i++) begin
			if (noise && $urandom_range(0, 15) == 0) begin
				p = rand_pixel();
				p.op = OP_FLUSH;
				pending_pixels.push_back(p);
			end
			pending_pixels.push_back(rand_pixel());
		end
		for (int i = 0; i < w + 1; i++) begin
			p = rand_pixel();
			p.op = ($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_FLUSH;
			pending_pixels.push_back(p);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_PIXEL;
			{red_in, green_in, blue_in, alpha_in} <= '0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) predict_pixel({opcode, red_in, green_in, blue_in, alpha_in});
			if (pending_pixels.size() != 0 && (no_idle || $urandom_range(0, 99) >= 7)) begin
				{opcode, red_in, green_in, blue_in, alpha_in} <= pending_pixels.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_pixels.size() == 0) begin
					$display("%0t unexpected transaction %h", $time,
						{red_out, green_out, blue_out, alpha_out, frame_end});
					errors++;
				end else begin
					want = expected_pixels.pop_front();
					if (want != {red_out, green_out, blue_out, alpha_out, frame_end}) begin
						$display({"%0t mismatch expected r%h g%h b%h a%h fe%b",
							" actual r%h g%h b%h a%h fe%b"},
							$time, want.r, want.g, want.b, want.a, want.fe,
							red_out, green_out, blue_out, alpha_out, frame_end);
						errors++;
					end
				end
			end
			out_stall <= !no_idle && ($urandom_range(0, 99) < 7);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || drain_done
				|| (pending_pixels.size() == 0 && expected_pixels.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_MAX) begin
			$display("tb_sobel_edge_blend_top failed");
			$finish;
		end
	end

	initial begin
		pix_t p;
		errors = 0;
		results_seen = 0;
		quiet_cycles = 0;
		no_idle = 0;
		drain_done = 0;
		cfg_we = 0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = 0;
		m_w = 640; m_h = 480; m_ew = 205; m_ow = 179;
		m_center = 0; m_col = 0; m_row = 0;
		for (int i = 0; i < MAXW; i++) begin
			m_upper[i] = 0;
			m_lower[i] = 0;
		end
		for (int i = 0; i < 9; i++) m_win[i / 3][i % 3] = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 4x4 frame with extremes, flush inside the frame
		setup(4, 4, 255, 255);
		for (int i = 0; i < 16; i++) begin
			p = rand_pixel();
			if (i % 3 == 0)
				{p.r, p.g, p.b, p.a} = 32'hffffffff;
			else if (i % 3 == 1)
				{p.r, p.g, p.b, p.a} = 32'h0;
			pending_pixels.push_back(p);
			if (i == 5) begin
				p.op = OP_FLUSH;
				pending_pixels.push_back(p);
			end
		end
		for (int i = 0; i < 5; i++) begin
			p = rand_pixel();
			p.op = (i == 0) ? OP_PIXEL : OP_FLUSH;
			pending_pixels.push_back(p);
		end
		// out-of-range sizes clamp to 3x3 with zero weights; then 3x3 with zero edge weight
		setup(0, 1, 0, 0);
		queue_frame(3, 3, 0);
		setup(3, 3, 0, 255);
		queue_frame(3, 3, 0);

		// random phases; one without idling
		for (int ph = 0; ph < 10; ph++) begin
			int unsigned w, h;
			w = $urandom_range(3, 9);
			h = $urandom_range(3, 7);
			setup(w, h, $urandom_range(0, 255), $urandom_range(0, 255));
			no_idle = (ph == 4);
			queue_frame(w, h, 1);
			if (ph == 6) queue_frame(w, h, 0);
		end
		no_idle = 0;
		wait_idle();
		drain_done = 1;
		$display("covered %0d results over clamped and small random frames", results_seen);
		$display("weights swept from 0 to 255 with stray flushes and random stalls");
		if (errors == 0)
			$display("tb_sobel_edge_blend_top passed");
		else
			$display("tb_sobel_edge_blend_top failed");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/core/seb_pkg.sv
rtl/core/seb_ram.sv
rtl/core/seb_fifo.sv
rtl/core/seb_front.sv
rtl/core/seb_back.sv
rtl/core/sobel_edge_blend_top.sv
verif/tb_sobel_edge_blend_top.sv
